@@ sv/ntc_pkg.sv @@
package ntc_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int STATUS_W = 2;
  localparam int TEMP_W   = 7;
  localparam int LEVEL_W  = 12;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 1;

  // Filter sum: 3*acc + sample fits in two extra bits
  localparam int FILT_SUM_W = LEVEL_W + 2;

  // Table geometry
  localparam int TABLE_ENTRIES_DEF = 101;
  localparam int ROM_LEN           = 101;
  localparam int ROM_IDX_W         = 7;

  localparam logic [TEMP_W-1:0]  TEMP_MAX     = TEMP_W'(100);
  localparam logic [LEVEL_W-1:0] FILTER_RESET = LEVEL_W'(672);
  localparam logic [LEVEL_W-1:0] LEVEL_TOP    = LEVEL_W'(4095);
  localparam logic [CFG_W-1:0]   SHORT_RESET  = CFG_W'(4000);
  localparam logic [CFG_W-1:0]   OPEN_RESET   = CFG_W'(100);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OPEN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WAIT
  } state_t;

  // Pull-down thermistor curve, 0..100 C, ascending
  localparam logic [LEVEL_W-1:0] CURVE_ROM [ROM_LEN] = '{
    12'd127,
    12'd133,  12'd139,  12'd146,  12'd153,  12'd160,
    12'd168,  12'd176,  12'd184,  12'd193,  12'd201,
    12'd210,  12'd220,  12'd229,  12'd239,  12'd250,
    12'd261,  12'd272,  12'd283,  12'd295,  12'd307,
    12'd319,  12'd332,  12'd346,  12'd359,  12'd373,
    12'd388,  12'd403,  12'd418,  12'd433,  12'd449,
    12'd466,  12'd483,  12'd500,  12'd518,  12'd536,
    12'd554,  12'd573,  12'd592,  12'd612,  12'd632,
    12'd653,  12'd674,  12'd695,  12'd717,  12'd739,
    12'd761,  12'd784,  12'd807,  12'd831,  12'd855,
    12'd879,  12'd904,  12'd929,  12'd954,  12'd980,
    12'd1006, 12'd1032, 12'd1059, 12'd1085, 12'd1112,
    12'd1140, 12'd1167, 12'd1195, 12'd1223, 12'd1251,
    12'd1280, 12'd1308, 12'd1337, 12'd1366, 12'd1395,
    12'd1424, 12'd1453, 12'd1483, 12'd1512, 12'd1542,
    12'd1571, 12'd1601, 12'd1631, 12'd1660, 12'd1690,
    12'd1720, 12'd1749, 12'd1779, 12'd1808, 12'd1838,
    12'd1867, 12'd1896, 12'd1926, 12'd1955, 12'd1984,
    12'd2013, 12'd2041, 12'd2070, 12'd2098, 12'd2126,
    12'd2154, 12'd2182, 12'd2210, 12'd2237, 12'd2264
  };

  // Entries past the curve read as full scale
  function automatic logic [LEVEL_W-1:0] rom_read(input logic [ROM_IDX_W-1:0] idx);
    logic [LEVEL_W-1:0] val;
    val = LEVEL_TOP;
    if (idx < ROM_IDX_W'(ROM_LEN)) begin
      val = CURVE_ROM[idx];
    end
    return val;
  endfunction

endpackage

@@ sv/ntc_if.sv @@
interface ntc_in_if;
  import ntc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ntc_out_if;
  import ntc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TEMP_W-1:0]   temperature;
  logic [LEVEL_W-1:0]  filtered_level;

  modport source (output valid, output status, output temperature, output filtered_level,
                  input ready);
  modport sink   (input valid, input status, input temperature, input filtered_level,
                  output ready);
endinterface

@@ sv/ntc_search.sv @@
module ntc_search #(
  parameter int TABLE_ENTRIES = ntc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ntc_pkg::LEVEL_W-1:0] level,
  output logic                        done,
  output logic [ntc_pkg::TEMP_W-1:0]  result
);
  import ntc_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic             run_r, run_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic             hit;
  logic [TEMP_W-1:0] idx_ext;

  // Midpoint and the one shared table compare
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDX_W:1];
  assign hit     = rom_read(ROM_IDX_W'(mid)) >= level;

  assign done = run_r && (lo_r == hi_r);

  // Clamp the found index to the top of the range
  assign idx_ext = TEMP_W'(lo_r);
  assign result  = (idx_ext > TEMP_MAX) ? TEMP_MAX : idx_ext;

  // Narrow the bracket by one half per cycle
  always_comb begin
    run_nxt = run_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (start) begin
      run_nxt = 1'b1;
      lo_nxt  = '0;
      hi_nxt  = LAST_IDX;
    end else if (done) begin
      run_nxt = 1'b0;
    end else if (run_r) begin
      if (hit) begin
        hi_nxt = mid;
      end else begin
        lo_nxt = mid + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

endmodule

@@ sv/ntc_adc_temperature_lookup.sv @@
// NTC thermistor lookup: each 12-bit converter sample is checked against the
// short and open thresholds (short wins when both match); either fault
// reports its status with the filter and temperature held. Any other sample
// updates the filter (3*level + sample)/4 and a binary search over the
// ascending curve table yields the temperature, 0..100 C. One transaction
// is in work at a time. A fault sample moves the block from idle to the
// wait state, which loads its result into the output register once that
// register is free; the next sample is taken after the return to idle. A
// good sample starts the search, which uses the single table compare and
// steps through one halving per cycle; when it ends, the temperature is
// latched and the block moves to the wait state, which loads the output
// register once it is free, and the next sample is taken after the return
// to idle. A finished result sits in an output register, so the next
// sample is taken while it waits to be read; the following result holds
// until that register is read, and the input stalls meanwhile.
// Configuration writes land at once; write only while idle.
module ntc_adc_temperature_lookup #(
  parameter int TABLE_ENTRIES = ntc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ntc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntc_pkg::CFG_W-1:0]     cfg_wdata,
  ntc_in_if.sink                        in_ch,
  ntc_out_if.source                     out_ch
);
  import ntc_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]    short_thr_r;
  logic [CFG_W-1:0]    open_thr_r;
  logic [LEVEL_W-1:0]  acc_r;
  logic [TEMP_W-1:0]   temp_r;
  logic [STATUS_W-1:0] status_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TEMP_W-1:0]   out_temp_r;
  logic [LEVEL_W-1:0]  out_level_r;

  logic                in_fire;
  logic                is_short;
  logic                is_open;
  logic                good;
  logic [STATUS_W-1:0] status_code;
  logic [FILT_SUM_W-1:0] filt_sum;
  logic                out_free;
  logic                out_load;
  logic                srch_start;
  logic                srch_done;
  logic [TEMP_W-1:0]   srch_result;

  ntc_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .level (acc_r),
    .done  (srch_done),
    .result(srch_result)
  );

  // Classify the incoming sample
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign is_short = in_ch.sample >= short_thr_r;
  assign is_open  = in_ch.sample <= open_thr_r;
  assign good     = !is_short && !is_open;

  always_comb begin
    if (is_short) begin
      status_code = STAT_SHORT;
    end else if (is_open) begin
      status_code = STAT_OPEN;
    end else begin
      status_code = STAT_VALID;
    end
  end

  // Filter update: (3*acc + sample) / 4, truncated
  assign filt_sum = ({2'b00, acc_r} << 1) + {2'b00, acc_r} + {2'b00, in_ch.sample};

  assign out_free = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = good ? ST_SEARCH : ST_WAIT;
        end
      end
      ST_SEARCH: begin
        if (srch_done) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ch.ready = 1'b0;
    srch_start  = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        srch_start  = in_ch.valid && good;
      end
      ST_SEARCH: begin
      end
      ST_WAIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_thr_r <= SHORT_RESET;
      open_thr_r  <= OPEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT: short_thr_r <= cfg_wdata;
        REG_OPEN:  open_thr_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Filter and held temperature
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= FILTER_RESET;
      temp_r <= '0;
    end else begin
      if (in_fire && good) begin
        acc_r <= filt_sum[FILT_SUM_W-1:2];
      end
      if (state_r == ST_SEARCH && srch_done) begin
        temp_r <= srch_result;
      end
    end
  end

  // Hold the status of the transaction in work
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_code;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_temp_r   <= temp_r;
      out_level_r  <= acc_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.temperature    = out_temp_r;
  assign out_ch.filtered_level = out_level_r;

endmodule

@@ tb/sv/ntc_adc_temperature_lookup_tb.sv @@
`timescale 1ns / 1ps

module ntc_adc_temperature_lookup_tb;
  import ntc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PCT        = 7;
  localparam int TAIL_CYCLES     = 20;
  localparam int REPORT_MAX      = 10;
  localparam int CURVE_LEN       = 101;
  localparam int TEMP_TOP        = 100;
  localparam int PHASE_ITEMS     = 250;

  // Expected reading of the thermistor channel
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TEMP_W-1:0]   temperature;
    logic [LEVEL_W-1:0]  level;
  } reading_t;

  // Pull-down thermistor curve, one entry per degree from 0 to 100 C
  localparam logic [LEVEL_W-1:0] THERM_CURVE [CURVE_LEN] = '{
    12'd127,
    12'd133,  12'd139,  12'd146,  12'd153,  12'd160,
    12'd168,  12'd176,  12'd184,  12'd193,  12'd201,
    12'd210,  12'd220,  12'd229,  12'd239,  12'd250,
    12'd261,  12'd272,  12'd283,  12'd295,  12'd307,
    12'd319,  12'd332,  12'd346,  12'd359,  12'd373,
    12'd388,  12'd403,  12'd418,  12'd433,  12'd449,
    12'd466,  12'd483,  12'd500,  12'd518,  12'd536,
    12'd554,  12'd573,  12'd592,  12'd612,  12'd632,
    12'd653,  12'd674,  12'd695,  12'd717,  12'd739,
    12'd761,  12'd784,  12'd807,  12'd831,  12'd855,
    12'd879,  12'd904,  12'd929,  12'd954,  12'd980,
    12'd1006, 12'd1032, 12'd1059, 12'd1085, 12'd1112,
    12'd1140, 12'd1167, 12'd1195, 12'd1223, 12'd1251,
    12'd1280, 12'd1308, 12'd1337, 12'd1366, 12'd1395,
    12'd1424, 12'd1453, 12'd1483, 12'd1512, 12'd1542,
    12'd1571, 12'd1601, 12'd1631, 12'd1660, 12'd1690,
    12'd1720, 12'd1749, 12'd1779, 12'd1808, 12'd1838,
    12'd1867, 12'd1896, 12'd1926, 12'd1955, 12'd1984,
    12'd2013, 12'd2041, 12'd2070, 12'd2098, 12'd2126,
    12'd2154, 12'd2182, 12'd2210, 12'd2237, 12'd2264
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ntc_in_if  in_ch ();
  ntc_out_if out_ch ();

  ntc_adc_temperature_lookup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow of the block's thresholds, filter and held temperature
  logic [CFG_W-1:0]   short_thr = SHORT_RESET;
  logic [CFG_W-1:0]   open_thr  = OPEN_RESET;
  logic [LEVEL_W-1:0] filt_level = FILTER_RESET;
  logic [TEMP_W-1:0]  held_temp  = '0;

  reading_t    pending_readings [$];
  int unsigned sent_cnt     = 0;
  int unsigned seen_cnt     = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cnt    = 0;
  bit          idle_on      = 1'b1;
  int          hold_req     = 0;
  int          drift_target = 1200;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the reading that one sample produces and advance the shadow state
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] s);
    reading_t r;
    int       sum;
    int       deg;
    bit       found;
    if (s >= short_thr) begin
      r.status = STAT_SHORT;
    end else if (s <= open_thr) begin
      r.status = STAT_OPEN;
    end else begin
      r.status   = STAT_VALID;
      sum        = 3 * int'(filt_level) + int'(s);
      filt_level = LEVEL_W'(sum / 4);
      // First curve entry not below the level; past the top, clamp
      deg   = TEMP_TOP;
      found = 1'b0;
      for (int i = 0; i < CURVE_LEN && !found; i++) begin
        if (THERM_CURVE[i] >= filt_level) begin
          deg   = i;
          found = 1'b1;
        end
      end
      held_temp = TEMP_W'(deg);
    end
    r.temperature = held_temp;
    r.level       = filt_level;
    return r;
  endfunction

  // Draw a sample: mostly a drifting level inside the good window, some uniform inside it, some anywhere
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int lo;
    int hi;
    int r;
    int v;
    lo = int'(open_thr) + 1;
    hi = int'(short_thr) - 1;
    r  = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) begin
      drift_target = $urandom_range(90, 2400);
    end
    if (lo > hi || r >= 80) begin
      v = $urandom_range(0, 4095);
    end else if (r < 55) begin
      v = drift_target + int'($urandom_range(0, 64)) - 32;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
    end else begin
      v = $urandom_range(hi, lo);
    end
    return SAMPLE_W'(v);
  endfunction

  // Check each result transaction against the oldest expectation, then predict
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen_cnt++;
        if (pending_readings.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("unexpected reading: status %0d temp %0d level %0d",
                     out_ch.status, out_ch.temperature, out_ch.filtered_level);
          end
        end else begin
          want = pending_readings.pop_front();
          if (out_ch.status !== want.status || out_ch.temperature !== want.temperature ||
              out_ch.filtered_level !== want.level) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("reading %0d mismatch: expected status %0d temp %0d level %0d",
                       seen_cnt, want.status, want.temperature, want.level);
              $display("  got status %0d temp %0d level %0d",
                       out_ch.status, out_ch.temperature, out_ch.filtered_level);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_readings.push_back(predict_reading(in_ch.sample));
      end
    end
  end

  // Count cycles without any transaction; abort when the block hangs
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive ready: random gaps, plus a long hold-off on request
  initial begin : drive_ready
    int hold_left;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_cnt++;
  endtask

  // Drop valid and wait until every reading has come back
  task automatic finish_burst();
    in_ch.valid <= 1'b0;
    while (seen_cnt < sent_cnt) @(posedge clk);
  endtask

  // Write both thresholds, short first
  task automatic write_thresholds(input logic [CFG_W-1:0] short_v,
                                  input logic [CFG_W-1:0] open_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHORT;
    cfg_wdata <= short_v;
    @(posedge clk);
    short_thr = short_v;
    cfg_index <= REG_OPEN;
    cfg_wdata <= open_v;
    @(posedge clk);
    open_thr = open_v;
    cfg_we <= 1'b0;
  endtask

  // Reset thresholds: both faults at their edges, saturation above the curve
  task automatic test_faults_and_clamp();
    logic [SAMPLE_W-1:0] pts [14] = '{
      12'd0, 12'd4095, 12'd4000, 12'd100, 12'd3999, 12'd3999, 12'd3999,
      12'd101, 12'd2264, 12'd2265, 12'd127, 12'd128, 12'd2730, 12'd1365
    };
    foreach (pts[i]) send_sample(pts[i]);
    finish_burst();
  endtask

  // Overlapping and extreme threshold settings; short takes priority
  task automatic test_threshold_extremes();
    write_thresholds(12'd200, 12'd3000);
    send_sample(12'd0);
    send_sample(12'd150);
    send_sample(12'd200);
    send_sample(12'd3000);
    send_sample(12'd4095);
    finish_burst();
    write_thresholds(12'd0, 12'd4095);
    send_sample(12'd0);
    send_sample(12'd2048);
    send_sample(12'd4095);
    finish_burst();
    write_thresholds(12'd4095, 12'd0);
    send_sample(12'd0);
    send_sample(12'd1);
    send_sample(12'd4094);
    send_sample(12'd4095);
    finish_burst();
  endtask

  // Random samples across several threshold settings
  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       write_thresholds(SHORT_RESET, OPEN_RESET);
        1:       write_thresholds(12'd4095, 12'd0);
        2:       write_thresholds(CFG_W'($urandom_range(2300, 4095)),
                                  CFG_W'($urandom_range(0, 126)));
        default: write_thresholds(CFG_W'($urandom), CFG_W'($urandom));
      endcase
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      finish_burst();
    end
  endtask

  // Back-to-back traffic with no gaps on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    write_thresholds(CFG_W'($urandom_range(2300, 4095)), CFG_W'($urandom_range(0, 126)));
    repeat (PHASE_ITEMS) send_sample(pick_sample());
    finish_burst();
    idle_on = 1'b1;
  endtask

  // Hold off the result side so the block fills and stalls its input
  task automatic test_output_stall();
    write_thresholds(SHORT_RESET, OPEN_RESET);
    hold_req = HOLD_OFF_CYCLES;
    repeat (40) send_sample(pick_sample());
    finish_burst();
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_SHORT;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_faults_and_clamp();
    test_threshold_extremes();
    test_random_phases();
    test_full_rate();
    test_output_stall();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ntc_pkg.sv
sv/ntc_if.sv
sv/ntc_search.sv
sv/ntc_adc_temperature_lookup.sv
tb/sv/ntc_adc_temperature_lookup_tb.sv
